@@ rtl/hms_pkg.sv @@
// Shared types, constants and helpers for the heightmap bilinear sampler.
`default_nettype none
package hms_pkg;

  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int DIM_W       = 9;
  localparam int STORE_DEPTH = 65536;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int COORD_W     = 24;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PW     = $clog2(FIFO_DEPTH);

  localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);
  localparam logic [DIM_W-1:0] DIM_MIN   = 9'd2;

  localparam logic [COORD_W-1:0] ONE_Q16 = 24'h01_0000;
  localparam logic [15:0]        ONE_Q14 = 16'd16384;

  // Input mode codes.
  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_HEIGHT = 2'd1;
  localparam logic [1:0] MODE_NORMAL = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] REG_HEIGHT_SCL = 2'd2;
  localparam logic [1:0] REG_INV_PATCH  = 2'd3;

  typedef enum logic [2:0] {
    KIND_WRITE,
    KIND_ZERO,
    KIND_FLAT,
    KIND_HEIGHT,
    KIND_NORMAL
  } kind_e;

  typedef struct packed {
    logic [DIM_W-1:0] map_width;
    logic [DIM_W-1:0] map_height;
    logic [15:0]      height_scale;
    logic [15:0]      inv_two_patch_world;
  } cfg_t;

  typedef struct packed {
    kind_e              kind;
    logic [COORD_W-1:0] fx;
    logic [COORD_W-1:0] fz;
    logic [COORD_W-1:0] fxl;
    logic [COORD_W-1:0] fxr;
    logic [COORD_W-1:0] fzd;
    logic [COORD_W-1:0] fzu;
    logic [15:0]        texel_index;
    logic [7:0]         texel_value;
  } item_t;

  function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] maxv);
    clamp_dim = (v > maxv) ? maxv : v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/hms_if.sv @@
// Handshake interfaces for the sampler's input, result and configuration channels.
`default_nettype none
interface hms_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] u_coord;
  logic signed [31:0] v_coord;
  logic [15:0]        texel_index;
  logic [7:0]         texel_value;
  modport source (output valid, mode, u_coord, v_coord, texel_index, texel_value,
                  input ready);
  modport sink   (input valid, mode, u_coord, v_coord, texel_index, texel_value,
                  output ready);
endinterface

interface hms_out_if;
  logic               valid;
  logic               ready;
  logic [23:0]        height;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  modport source (output valid, height, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, height, normal_x, normal_y, normal_z, output ready);
endinterface

interface hms_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/hms_ram.sv @@
// Generic single-port RAM with registered read data.
`default_nettype none
module hms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule
`default_nettype wire

@@ rtl/hms_front.sv @@
// Front end: classifies each input item and maps its coordinates into texel space.
`default_nettype none
module hms_front
  import hms_pkg::*;
(
  input  wire cfg_t  cfg_i,
  hms_in_if.sink     in_i,
  output logic       push_valid_o,
  input  wire logic  push_ready_i,
  output item_t      push_data_o
);

  logic [DIM_W-1:0]   w, h;
  logic [DIM_W-1:0]   wm1_full, hm1_full;
  logic [7:0]         wm1, hm1;
  logic               no_map;
  logic [COORD_W-1:0] fx, fz, px, pz;
  logic [COORD_W:0]   sx, sz;

  always_comb begin
    w        = clamp_dim(cfg_i.map_width, DIM_MAX_W);
    h        = clamp_dim(cfg_i.map_height, DIM_MAX_H);
    no_map   = (w < DIM_MIN) || (h < DIM_MIN);
    wm1_full = w - 9'd1;
    hm1_full = h - 9'd1;
    wm1      = wm1_full[7:0];
    hm1      = hm1_full[7:0];
    fx = {8'd0, in_i.u_coord[15:0]} * {16'd0, wm1};
    fz = {8'd0, in_i.v_coord[15:0]} * {16'd0, hm1};
    px = {wm1, 16'd0};
    pz = {hm1, 16'd0};
    sx = {1'b0, fx} + {1'b0, ONE_Q16};
    sz = {1'b0, fz} + {1'b0, ONE_Q16};

    push_data_o.fx  = fx;
    push_data_o.fz  = fz;
    // Neighbor coordinates wrap with a period of one texel less than the map size.
    push_data_o.fxl = (fx >= ONE_Q16) ? (fx - ONE_Q16) : (fx + px - ONE_Q16);
    push_data_o.fzd = (fz >= ONE_Q16) ? (fz - ONE_Q16) : (fz + pz - ONE_Q16);
    push_data_o.fxr = (sx >= {1'b0, px}) ? COORD_W'(sx - {1'b0, px}) : sx[COORD_W-1:0];
    push_data_o.fzu = (sz >= {1'b0, pz}) ? COORD_W'(sz - {1'b0, pz}) : sz[COORD_W-1:0];
    push_data_o.texel_index = in_i.texel_index;
    push_data_o.texel_value = in_i.texel_value;

    case (in_i.mode)
      MODE_WRITE:  push_data_o.kind = KIND_WRITE;
      MODE_HEIGHT: push_data_o.kind = no_map ? KIND_ZERO : KIND_HEIGHT;
      MODE_NORMAL: push_data_o.kind = no_map ? KIND_FLAT : KIND_NORMAL;
      default:     push_data_o.kind = KIND_ZERO;
    endcase
  end

  assign push_valid_o = in_i.valid;
  assign in_i.ready   = push_ready_i;

endmodule
`default_nettype wire

@@ rtl/hms_fifo.sv @@
// Short queue of classified items between the front end and the back end.
`default_nettype none
module hms_fifo
  import hms_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire item_t push_data_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output item_t      pop_data_o
);

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_PW:0]   count_q;
  logic               do_push, do_pop;

  assign push_ready_o = (count_q != (FIFO_PW+1)'(FIFO_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        mem_q[wr_ptr_q] <= push_data_i;
        wr_ptr_q        <= FIFO_PW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= FIFO_PW'(rd_ptr_q + 1'b1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/hms_back.sv @@
// Back end: texel store, bilinear sampling, slopes, square root and normalization.
`default_nettype none
module hms_back
  import hms_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire logic  pop_valid_i,
  output logic       pop_ready_o,
  input  wire item_t pop_data_i,
  hms_out_if.source  out_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_BASE, S_READ, S_WAIT, S_LA, S_LB, S_R1, S_R2, S_H1, S_H2, S_H3, S_H4,
    S_SLX, S_SLX2, S_SLZ, S_SLZ2, S_SQ1, S_SQ2, S_SQ3, S_SQRT, S_DVS, S_DIV, S_FIN
  } state_e;

  state_e             state_q;
  item_t              item_q;
  logic [1:0]         sidx_q, rd_cnt_q, rd_idx_q, comp_q;
  logic               rd_pend_q;
  logic [15:0]        base_q, tx_q, tz_q;
  logic [7:0]         tex_q [4];
  logic [24:0]        a_q, b_q;
  logic [63:0]        mul_q;
  logic [39:0]        r_q;
  logic [56:0]        n_q;
  logic [23:0]        samp_q [4];
  logic               negx_q, negz_q;
  logic [23:0]        mx_q, mz_q;
  logic [63:0]        op_q, res_q, bit_q;
  logic [4:0]         sq_cnt_q;
  logic [30:0]        len_q;
  logic [44:0]        dq_q;
  logic [31:0]        rem_q;
  logic [5:0]         dcnt_q;
  logic [23:0]        hres_q;
  logic [15:0]        nx_q, ny_q, nz_q;
  logic               out_valid_q;
  logic [23:0]        out_height_q;
  logic [15:0]        out_nx_q, out_ny_q, out_nz_q;

  logic [DIM_W-1:0]   w;
  logic [COORD_W-1:0] cx, cz;
  logic [17:0]        base_full;
  logic [15:0]        rd_off;
  logic               ram_we;
  logic [STORE_AW-1:0] ram_addr;
  logic [7:0]         ram_rdata;
  logic [31:0]        mul_a, mul_b;
  logic [63:0]        product;
  logic [23:0]        diff_x, diff_z;
  logic [40:0]        slope_sum;
  logic [63:0]        sq_trial;
  logic [31:0]        div_t;
  logic               div_ge;
  logic [24:0]        mag;
  logic [44:0]        dq_next;
  logic [15:0]        q16;
  logic               out_free;

  assign w = clamp_dim(cfg_i.map_width, DIM_MAX_W);

  // Coordinates of the sample under work: the center for a height, a neighbor for a normal.
  always_comb begin
    cx = item_q.fx;
    cz = item_q.fz;
    if (item_q.kind == KIND_NORMAL) begin
      case (sidx_q)
        2'd0:    cx = item_q.fxl;
        2'd1:    cx = item_q.fxr;
        2'd2:    cz = item_q.fzd;
        default: cz = item_q.fzu;
      endcase
    end
    base_full = {10'd0, cz[23:16]} * {9'd0, w} + {10'd0, cx[23:16]};
  end

  always_comb begin
    case (rd_cnt_q)
      2'd0:    rd_off = 16'd0;
      2'd1:    rd_off = 16'd1;
      2'd2:    rd_off = 16'(w);
      default: rd_off = 16'(w) + 16'd1;
    endcase
  end

  assign ram_we   = (state_q == S_IDLE) && pop_valid_i && (pop_data_i.kind == KIND_WRITE);
  assign ram_addr = ram_we ? pop_data_i.texel_index : STORE_AW'(base_q + rd_off);

  hms_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (pop_data_i.texel_value),
    .rdata_o (ram_rdata)
  );

  // Multiplier shared by the blend, scaling, slope and square states; each state picks its operands.
  always_comb begin
    diff_x = (samp_q[0] < samp_q[1]) ? (samp_q[1] - samp_q[0]) : (samp_q[0] - samp_q[1]);
    diff_z = (samp_q[2] < samp_q[3]) ? (samp_q[3] - samp_q[2]) : (samp_q[2] - samp_q[3]);
    case (state_q)
      S_R1:    begin mul_a = 32'(a_q);         mul_b = 32'(17'h1_0000 - {1'b0, tz_q}); end
      S_R2:    begin mul_a = 32'(b_q);         mul_b = 32'(tz_q);                       end
      S_H1:    begin mul_a = 32'(r_q[19:0]);   mul_b = 32'(cfg_i.height_scale);         end
      S_H2:    begin mul_a = 32'(r_q[39:20]);  mul_b = 32'(cfg_i.height_scale);         end
      S_H3:    begin mul_a = n_q[55:24];       mul_b = 32'h8080_8081;                   end
      S_SLX:   begin mul_a = 32'(diff_x);      mul_b = 32'(cfg_i.inv_two_patch_world);  end
      S_SLZ:   begin mul_a = 32'(diff_z);      mul_b = 32'(cfg_i.inv_two_patch_world);  end
      S_SQ1:   begin mul_a = 32'(mx_q);        mul_b = 32'(mx_q);                       end
      S_SQ2:   begin mul_a = 32'(mz_q);        mul_b = 32'(mz_q);                       end
      default: begin mul_a = '0;               mul_b = '0;                              end
    endcase
    product   = {32'd0, mul_a} * {32'd0, mul_b};
    slope_sum = 41'(mul_q[39:0]) + 41'd32768;
    sq_trial  = res_q + bit_q;
    div_t     = {rem_q[30:0], dq_q[44]};
    div_ge    = (div_t >= {1'b0, len_q});
    dq_next   = {dq_q[43:0], div_ge};
    q16       = dq_next[15:0];
    case (comp_q)
      2'd0:    mag = {1'b0, mx_q};
      2'd1:    mag = 25'h1_0000;
      default: mag = {1'b0, mz_q};
    endcase
  end

  assign out_free    = !out_valid_q || out_o.ready;
  assign pop_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mul_q     <= product;
      rd_pend_q <= (state_q == S_READ);
      rd_idx_q  <= rd_cnt_q;
      if (rd_pend_q) begin
        tex_q[rd_idx_q] <= ram_rdata;
      end
      if (out_valid_q && out_o.ready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (pop_valid_i) begin
            item_q <= pop_data_i;
            sidx_q <= 2'd0;
            hres_q <= '0;
            nx_q   <= '0;
            ny_q   <= (pop_data_i.kind == KIND_FLAT) ? ONE_Q14 : 16'd0;
            nz_q   <= '0;
            if (pop_data_i.kind == KIND_HEIGHT || pop_data_i.kind == KIND_NORMAL) begin
              state_q <= S_BASE;
            end else begin
              state_q <= S_FIN;
            end
          end
        end
        S_BASE: begin
          base_q   <= base_full[15:0];
          tx_q     <= cx[15:0];
          tz_q     <= cz[15:0];
          rd_cnt_q <= 2'd0;
          state_q  <= S_READ;
        end
        S_READ: begin
          rd_cnt_q <= rd_cnt_q + 2'd1;
          if (rd_cnt_q == 2'd3) begin
            state_q <= S_WAIT;
          end
        end
        S_WAIT: state_q <= S_LA;
        S_LA: begin
          a_q <= 25'(tex_q[0]) * 25'(17'h1_0000 - {1'b0, tx_q}) + 25'(tex_q[1]) * 25'(tx_q);
          state_q <= S_LB;
        end
        S_LB: begin
          b_q <= 25'(tex_q[2]) * 25'(17'h1_0000 - {1'b0, tx_q}) + 25'(tex_q[3]) * 25'(tx_q);
          state_q <= S_R1;
        end
        S_R1: state_q <= S_R2;
        S_R2: begin
          r_q     <= 40'(mul_q) + 40'(product);
          state_q <= S_H1;
        end
        S_H1: state_q <= S_H2;
        S_H2: begin
          // Rounding term of the division by 255 * 2^24 is added before the shift.
          n_q     <= 57'(mul_q) + 57'({product[36:0], 20'd0}) + (57'd255 << 23);
          state_q <= S_H3;
        end
        S_H3: state_q <= S_H4;
        S_H4: begin
          samp_q[sidx_q] <= mul_q[62:39];
          if (item_q.kind == KIND_HEIGHT) begin
            hres_q  <= mul_q[62:39];
            state_q <= S_FIN;
          end else if (sidx_q == 2'd3) begin
            state_q <= S_SLX;
          end else begin
            sidx_q  <= sidx_q + 2'd1;
            state_q <= S_BASE;
          end
        end
        S_SLX: begin
          negx_q  <= (samp_q[0] < samp_q[1]);
          negz_q  <= (samp_q[2] < samp_q[3]);
          state_q <= S_SLX2;
        end
        S_SLX2: begin
          mx_q    <= slope_sum[39:16];
          state_q <= S_SLZ;
        end
        S_SLZ: state_q <= S_SLZ2;
        S_SLZ2: begin
          mz_q    <= slope_sum[39:16];
          state_q <= S_SQ1;
        end
        S_SQ1: state_q <= S_SQ2;
        S_SQ2: begin
          op_q    <= mul_q;
          state_q <= S_SQ3;
        end
        S_SQ3: begin
          op_q     <= (op_q + mul_q + 64'h1_0000_0000) << 12;
          res_q    <= '0;
          bit_q    <= 64'd1 << 62;
          sq_cnt_q <= '0;
          state_q  <= S_SQRT;
        end
        S_SQRT: begin
          if (op_q >= sq_trial) begin
            op_q  <= op_q - sq_trial;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q    <= bit_q >> 2;
          sq_cnt_q <= sq_cnt_q + 5'd1;
          if (sq_cnt_q == 5'd31) begin
            state_q <= S_DVS;
            comp_q  <= 2'd0;
          end
        end
        S_DVS: begin
          if (sq_cnt_q == 5'd0 && comp_q == 2'd0) begin
            len_q <= res_q[30:0];
          end
          dq_q    <= {mag, 20'd0} + 45'((comp_q == 2'd0) ? res_q[30:1] : len_q[30:1]);
          rem_q   <= '0;
          dcnt_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          rem_q  <= div_ge ? (div_t - {1'b0, len_q}) : div_t;
          dq_q   <= dq_next;
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd44) begin
            case (comp_q)
              2'd0:    nx_q <= negx_q ? (16'd0 - q16) : q16;
              2'd1:    ny_q <= q16;
              default: nz_q <= negz_q ? (16'd0 - q16) : q16;
            endcase
            if (comp_q == 2'd2) begin
              state_q <= S_FIN;
            end else begin
              comp_q  <= comp_q + 2'd1;
              state_q <= S_DVS;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_height_q <= hres_q;
            out_nx_q     <= nx_q;
            out_ny_q     <= ny_q;
            out_nz_q     <= nz_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.height   = out_height_q;
  assign out_o.normal_x = out_nx_q;
  assign out_o.normal_y = out_ny_q;
  assign out_o.normal_z = out_nz_q;

endmodule
`default_nettype wire

@@ rtl/heightmap_bilinear_sampler.sv @@
// Top level of the heightmap bilinear sampler: configuration registers and the two halves.
//
// Channels: in_i takes one item per beat (mode, coordinates, texel address and value),
// out_o returns exactly one result beat per input item, in order, and cfg_i writes the
// map width, map height, height scale and slope scale by register index.
// Items in the queue and the back end read the live registers, so the user must write
// configuration only while no item is in flight; the block itself does not enforce it.
// The back end's sequencer and its single store port handle one item at a time.
// A texel write, an unused mode or an item with no map goes straight to the result
// state; a height sample takes four texel reads and a five-step multiply chain for the
// blend and scaling; a normal takes four such samples, the slope and square states,
// 32 square-root steps and three one-bit-per-cycle divisions of 45 steps plus a setup
// step each.
// The front end classifies items and feeds a two-entry queue, so up to two items are
// accepted while the back end is busy.
// Reset clears the queue, the sequencer, the result register and the configuration
// (width and height 0, height scale 1.0, slope scale 0.5); the texel store is not
// cleared and holds its contents undefined until written.
// When the receiver stalls, the result beat is held in the output register and the back
// end waits with its next result; the queue then fills and in_i.ready drops.
`default_nettype none
module heightmap_bilinear_sampler
  import hms_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hms_cfg_if.sink    cfg_i,
  hms_in_if.sink     in_i,
  hms_out_if.source  out_o
);

  cfg_t  cfg_q;
  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_data, pop_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.map_width           <= '0;
      cfg_q.map_height          <= '0;
      cfg_q.height_scale        <= 16'd256;
      cfg_q.inv_two_patch_world <= 16'd32768;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_MAP_WIDTH:  cfg_q.map_width           <= cfg_i.data[DIM_W-1:0];
        REG_MAP_HEIGHT: cfg_q.map_height          <= cfg_i.data[DIM_W-1:0];
        REG_HEIGHT_SCL: cfg_q.height_scale        <= cfg_i.data;
        REG_INV_PATCH:  cfg_q.inv_two_patch_world <= cfg_i.data;
        default: ;
      endcase
    end
  end

  hms_front u_front (
    .cfg_i        (cfg_q),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  hms_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  hms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule
`default_nettype wire
